[hdl/tmip_pkg.sv]
// Shared types, character codes and header table for the tagged message parser.
`default_nettype none

package tmip_pkg;

    localparam int CFG_DATA_BITS = 64;
    localparam int LEN_OUT_BITS  = 16;
    localparam int HDR_LAST      = 4;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_OUT,
        PH_SLASH,
        PH_KEY,
        PH_AFTER_KEY,
        PH_VALUE,
        PH_ESCAPE,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_KEY,
        ST_BAD,
        ST_INCOMPLETE
    } status_t;

    typedef enum logic {
        CFG_KEY_TEXT,
        CFG_KEY_LENGTH
    } cfg_index_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic                      emit;
        status_t                   status;
        logic [31:0]               value;
        logic [LEN_OUT_BITS-1:0]   length;
    } result_t;

    // "<msg " header, one character per position
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h3C;
            3'd1:    c = 8'h6D;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h67;
            3'd4:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/tmip_if.sv]
// Channel interfaces: message bytes in, parse results out, configuration writes.
`default_nettype none

interface tmip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface tmip_out_if;
    logic                                 valid;
    logic                                 ready;
    tmip_pkg::status_t                    status;
    logic signed [31:0]                   value;
    logic [tmip_pkg::LEN_OUT_BITS-1:0]    message_length;

    modport source (output valid, output status, output value, output message_length,
                    input ready);
    modport sink   (input valid, input status, input value, input message_length,
                    output ready);
endinterface

interface tmip_cfg_if;
    logic                                 valid;
    logic                                 ready;
    tmip_pkg::cfg_index_t                 index;
    logic [tmip_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/tmip_core.sv]
// Parser state and per-byte step logic: header, key match, value accumulation.
`default_nettype none

module tmip_core #(
    parameter int MAX_KEY_BYTES = 8,
    parameter int LENGTH_BITS   = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic [7:0]                   byte_value,
    input  wire logic                         last_byte,
    input  wire logic [MAX_KEY_BYTES*8-1:0]   key_text,
    input  wire logic [3:0]                   key_length,
    output tmip_pkg::result_t                 res
);

    tmip_pkg::phase_t          phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]    pos_reg, pos_next;
    logic [3:0]                kidx_reg, kidx_next;
    logic                      kmatch_reg, kmatch_next;
    logic [31:0]               acc_reg, acc_next;
    logic                      neg_reg, neg_next;
    logic                      first_reg, first_next;
    logic                      bad_reg, bad_next;
    tmip_pkg::status_t         fstat_reg, fstat_next;
    logic [31:0]               fval_reg, fval_next;

    // value byte handling, shared by the value and escape phases
    logic        vb_neg, vb_bad;
    logic [31:0] vb_acc;
    logic [3:0]  digit;
    logic        is_digit;
    logic [31:0] pos_wide;
    logic        emit;
    logic        ended;
    tmip_pkg::status_t emit_status;
    logic [31:0]            emit_value;
    logic [LENGTH_BITS-1:0] emit_len;

    function automatic logic key_eq(input logic [3:0] idx, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int j = 0; j < MAX_KEY_BYTES; j++)
        begin
            if (idx == 4'(j) && idx < key_length && key_text[8*j +: 8] == b)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    assign digit    = 4'(byte_value - tmip_pkg::CH_ZERO);
    assign is_digit = byte_value >= tmip_pkg::CH_ZERO && byte_value <= tmip_pkg::CH_NINE;

    always_comb
    begin
        vb_neg = neg_reg;
        vb_acc = acc_reg;
        vb_bad = bad_reg;
        if (first_reg && byte_value == tmip_pkg::CH_MINUS)
        begin
            vb_neg = 1'b1;
        end
        else if (is_digit)
        begin
            // acc * 10 as two shifts and an add
            vb_acc = (acc_reg << 3) + (acc_reg << 1) + 32'(digit);
        end
        else
        begin
            vb_bad = 1'b1;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        kidx_next   = kidx_reg;
        kmatch_next = kmatch_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        first_next  = first_reg;
        bad_next    = bad_reg;
        fstat_next  = fstat_reg;
        fval_next   = fval_reg;
        emit        = 1'b0;
        ended       = 1'b0;
        emit_status = tmip_pkg::ST_INCOMPLETE;

        if (fire && phase_reg != tmip_pkg::PH_DISCARD)
        begin
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + 1'b1;
            end

            if (byte_value == tmip_pkg::CH_NUL)
            begin
                emit = 1'b1;
            end
            else
            begin
                unique case (phase_reg) inside
                    tmip_pkg::PH_HEADER:
                    begin
                        if (pos_reg > LENGTH_BITS'(tmip_pkg::HDR_LAST) ||
                            tmip_pkg::header_char(pos_reg[2:0]) != byte_value)
                        begin
                            emit = 1'b1;
                        end
                        else if (pos_reg == LENGTH_BITS'(tmip_pkg::HDR_LAST))
                        begin
                            phase_next = tmip_pkg::PH_OUT;
                        end
                    end
                    tmip_pkg::PH_OUT, tmip_pkg::PH_SLASH:
                    begin
                        if (phase_reg == tmip_pkg::PH_SLASH && byte_value == tmip_pkg::CH_GT)
                        begin
                            ended = 1'b1;
                        end
                        else if (byte_value == tmip_pkg::CH_SLASH)
                        begin
                            phase_next = tmip_pkg::PH_SLASH;
                        end
                        else if (byte_value != tmip_pkg::CH_SPACE)
                        begin
                            // any other byte opens a key and is its first character
                            kidx_next   = 4'd1;
                            kmatch_next = key_eq(4'd0, byte_value);
                            phase_next  = tmip_pkg::PH_KEY;
                        end
                        else
                        begin
                            phase_next = tmip_pkg::PH_OUT;
                        end
                    end
                    tmip_pkg::PH_KEY:
                    begin
                        if (byte_value == tmip_pkg::CH_EQ)
                        begin
                            kmatch_next = kmatch_reg && kidx_reg == key_length &&
                                          key_length <= 4'(MAX_KEY_BYTES);
                            phase_next  = tmip_pkg::PH_AFTER_KEY;
                        end
                        else
                        begin
                            kmatch_next = kmatch_reg && key_eq(kidx_reg, byte_value);
                            if (kidx_reg != 4'hF)
                            begin
                                kidx_next = kidx_reg + 4'd1;
                            end
                        end
                    end
                    tmip_pkg::PH_AFTER_KEY:
                    begin
                        if (byte_value == tmip_pkg::CH_QUOTE)
                        begin
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            first_next = 1'b1;
                            bad_next   = 1'b0;
                            phase_next = tmip_pkg::PH_VALUE;
                        end
                    end
                    tmip_pkg::PH_VALUE:
                    begin
                        if (byte_value == tmip_pkg::CH_QUOTE)
                        begin
                            if (kmatch_reg)
                            begin
                                fstat_next = bad_reg ? tmip_pkg::ST_BAD : tmip_pkg::ST_OK;
                                fval_next  = neg_reg ? (32'd0 - acc_reg) : acc_reg;
                            end
                            phase_next = tmip_pkg::PH_OUT;
                        end
                        else
                        begin
                            acc_next   = vb_acc;
                            neg_next   = vb_neg;
                            bad_next   = vb_bad;
                            first_next = 1'b0;
                            if (byte_value == tmip_pkg::CH_BSLASH)
                            begin
                                phase_next = tmip_pkg::PH_ESCAPE;
                            end
                        end
                    end
                    tmip_pkg::PH_ESCAPE:
                    begin
                        acc_next   = vb_acc;
                        neg_next   = vb_neg;
                        bad_next   = vb_bad;
                        first_next = 1'b0;
                        phase_next = tmip_pkg::PH_VALUE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                if (ended)
                begin
                    emit        = 1'b1;
                    emit_status = fstat_reg;
                end
            end

            if (last_byte)
            begin
                emit = 1'b1;
            end
            if (emit && !last_byte)
            begin
                phase_next = tmip_pkg::PH_DISCARD;
            end
        end

        // result fields come from the stepped state, before a last byte clears it
        emit_value = fval_next;
        emit_len   = pos_next;

        // a last byte always closes the buffer: start over on the next message
        if (fire && last_byte)
        begin
            phase_next  = tmip_pkg::PH_HEADER;
            pos_next    = '0;
            kidx_next   = '0;
            kmatch_next = 1'b1;
            acc_next    = '0;
            neg_next    = 1'b0;
            first_next  = 1'b1;
            bad_next    = 1'b0;
            fstat_next  = tmip_pkg::ST_NO_KEY;
            fval_next   = '0;
        end
    end

    // found value stays zero through the header, so a header mismatch reports zero too
    assign pos_wide      = 32'(emit_len);
    assign res.emit      = emit;
    assign res.status    = emit_status;
    assign res.value     = emit_value;
    assign res.length    = ended ? pos_wide[tmip_pkg::LEN_OUT_BITS-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tmip_pkg::PH_HEADER;
            pos_reg    <= '0;
            kidx_reg   <= '0;
            kmatch_reg <= 1'b1;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            first_reg  <= 1'b1;
            bad_reg    <= 1'b0;
            fstat_reg  <= tmip_pkg::ST_NO_KEY;
            fval_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            kidx_reg   <= kidx_next;
            kmatch_reg <= kmatch_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            first_reg  <= first_next;
            bad_reg    <= bad_next;
            fstat_reg  <= fstat_next;
            fval_reg   <= fval_next;
        end
    end

    a_emit_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |-> fire)
        else $error("result emitted without a byte beat");

    a_discard_after_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.emit && !last_byte |=> phase_reg == tmip_pkg::PH_DISCARD)
        else $error("buffer tail not discarded after result");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> phase_reg == tmip_pkg::PH_HEADER && pos_reg == '0)
        else $error("last byte did not restart header matching");

    a_complete_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit && res.status != tmip_pkg::ST_INCOMPLETE |-> emit_len != '0)
        else $error("complete message reported with zero length");

endmodule

`default_nettype wire

[hdl/tagged_message_int_field_parser.sv]
// Top level: input byte register, configuration registers, parser core, result register.
//
//   channel  modport  beat contents
//   bytes    sink     byte_value[7:0], last_byte
//   result   source   status[1:0], value[31:0] signed, message_length[15:0]
//   cfg      sink     index (0 key_text, 1 key_length), data[63:0]
//
// One byte beat per cycle, sustained while no result waits. A byte lands in the input register,
// is stepped through the combinational parser core once no result waits, and any result is
// captured in the result register as that byte is stepped. A waiting result stalls the input register and the core.
// Reset clears the parser state and both configuration registers; cfg is always ready.
`default_nettype none

module tagged_message_int_field_parser #(
    parameter int MAX_KEY_BYTES = 8,
    parameter int LENGTH_BITS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tmip_in_if.sink          bytes,
    tmip_out_if.source       result,
    tmip_cfg_if.sink         cfg
);

    localparam int KEY_BITS = MAX_KEY_BYTES * 8;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_last_reg;
    logic                   out_valid_reg;
    tmip_pkg::result_t      out_data_reg;
    logic [KEY_BITS-1:0]    key_text_reg;
    logic [3:0]             key_length_reg;
    logic                   out_free;
    logic                   fire;
    tmip_pkg::result_t      core_res;

    assign out_free    = !out_valid_reg || result.ready;
    assign fire        = s1_valid_reg && out_free;
    assign bytes.ready = !s1_valid_reg || fire;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            s1_byte_reg <= bytes.byte_value;
            s1_last_reg <= bytes.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg   <= '0;
            key_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tmip_pkg::CFG_KEY_TEXT:   key_text_reg   <= cfg.data[KEY_BITS-1:0];
                tmip_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg.data[3:0];
                default:                  key_length_reg <= key_length_reg;
            endcase
        end
    end

    tmip_core #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .byte_value (s1_byte_reg),
        .last_byte  (s1_last_reg),
        .key_text   (key_text_reg),
        .key_length (key_length_reg),
        .res        (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res.emit)
        begin
            out_data_reg <= core_res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_data_reg.status;
    assign result.value          = $signed(out_data_reg.value);
    assign result.message_length = out_data_reg.length;

endmodule

`default_nettype wire
